// ===== sv/rle_gray_sprite_blitter_macros.svh =====
// assertion macros used by the sprite blitter port checker
`ifndef RLE_GRAY_SPRITE_BLITTER_MACROS_SVH
`define RLE_GRAY_SPRITE_BLITTER_MACROS_SVH

// same-cycle implication
`define RGSB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgsb assertion failed");

// next-cycle implication
`define RGSB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgsb assertion failed");

`endif

// ===== sv/rgsb_pkg.sv =====
// shared types and constants of the run-length gray sprite blitter
package rgsb_pkg;

   localparam int RGSB_MAX_DIM = 256;
   localparam int RGSB_MAX_RUN = 64;
   localparam int RUN_W        = $clog2(RGSB_MAX_RUN);

   // configuration register indexes
   localparam logic [2:0] CSR_SPRITE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SPRITE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_X      = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_Y      = 3'd3;
   localparam logic [2:0] CSR_INK_LEVEL     = 3'd4;
   localparam logic [2:0] CSR_BG_LEVEL      = 3'd5;
   localparam logic [2:0] CSR_DRAW_MODE     = 3'd6;
   localparam logic [2:0] CSR_SCREEN_SIZE   = 3'd7;

   // draw modes
   localparam logic [1:0] MODE_OPAQUE = 2'd0;
   localparam logic [1:0] MODE_SCALED = 2'd1;

   // sprite status codes
   localparam logic [1:0] STATUS_RUNNING  = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [1:0] STATUS_SHORT    = 2'd3;

   // divide by three as multiply by 683 and shift right 11, exact below 2048
   localparam logic [9:0] DIV3_RECIP = 10'd683;
   localparam int         DIV3_SHIFT = 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_CHECK,
      ST_RUN,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic check;
      logic issue_pix;
      logic issue_err;
   } cmd_type;

   typedef struct packed {
      logic over;
      logic run_last;
      logic pipe_ready;
   } stat_type;

endpackage

// ===== sv/rgsb_ctrl.sv =====
// controller state machine: byte intake, overflow decision and pixel issue
module rgsb_ctrl import rgsb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.over ? ST_ERR : ST_RUN;
         end
         ST_RUN: begin
            if (stat.pipe_ready && stat.run_last) state_in = ST_IDLE;
         end
         ST_ERR: begin
            if (stat.pipe_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_RUN: begin
            cmd.issue_pix = stat.pipe_ready;
         end
         ST_ERR: begin
            cmd.issue_err = stat.pipe_ready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/rgsb_datapath.sv =====
// datapath: settings, sprite counters, gray blend and the pixel pipeline
module rgsb_datapath import rgsb_pkg::*; #(
   parameter int MAX_DIM = RGSB_MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic [7:0]  code_byte,
   input  logic        last_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] pixel_x,
   output logic [16:0] pixel_y,
   output logic [7:0]  gray_value,
   output logic        write_enable,
   output logic        run_end,
   output logic [1:0]  sprite_status
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int PIX_W = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int PROD_W = 2 * DIM_W;

   // settings
   logic [8:0]  width_ff;
   logic [8:0]  height_ff;
   logic [15:0] origin_x_ff;
   logic [15:0] origin_y_ff;
   logic [7:0]  ink_ff;
   logic [7:0]  bg_ff;
   logic [1:0]  mode_ff;
   logic [15:0] screen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 9'd1;
         height_ff   <= 9'd1;
         origin_x_ff <= 16'd0;
         origin_y_ff <= 16'd0;
         ink_ff      <= 8'd0;
         bg_ff       <= 8'd255;
         mode_ff     <= MODE_OPAQUE;
         screen_ff   <= 16'd46248;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPRITE_WIDTH:  width_ff    <= csr_wdata[8:0];
            CSR_SPRITE_HEIGHT: height_ff   <= csr_wdata[8:0];
            CSR_ORIGIN_X:      origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y:      origin_y_ff <= csr_wdata;
            CSR_INK_LEVEL:     ink_ff      <= csr_wdata[7:0];
            CSR_BG_LEVEL:      bg_ff       <= csr_wdata[7:0];
            CSR_DRAW_MODE:     mode_ff     <= csr_wdata[1:0];
            CSR_SCREEN_SIZE:   screen_ff   <= csr_wdata;
            default:           width_ff    <= width_ff;
         endcase
      end
   end

   // values derived from the settings, refreshed every cycle
   logic [DIM_W-1:0]  w_clamp;
   logic [DIM_W-1:0]  h_clamp;
   logic [PROD_W-1:0] area;
   logic [7:0]        radius;
   logic [DIM_W-1:0]  w_ff;
   logic [PIX_W-1:0]  total_ff;
   logic [8:0]        sw_ff;
   logic [8:0]        sh_ff;
   logic              square_ff;
   logic [15:0]       rsq_ff;

   always_comb begin
      if (width_ff == 9'd0) w_clamp = DIM_W'(1);
      else if (32'(width_ff) > 32'(MAX_DIM)) w_clamp = DIM_W'(MAX_DIM);
      else w_clamp = DIM_W'(width_ff);
      if (height_ff == 9'd0) h_clamp = DIM_W'(1);
      else if (32'(height_ff) > 32'(MAX_DIM)) h_clamp = DIM_W'(MAX_DIM);
      else h_clamp = DIM_W'(height_ff);
      area   = PROD_W'(w_clamp) * PROD_W'(h_clamp);
      radius = screen_ff[7:0] - 8'd1;
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_clamp;
      total_ff  <= area[PIX_W-1:0];
      sw_ff     <= {1'b0, screen_ff[7:0]} + 9'd1;
      sh_ff     <= {1'b0, screen_ff[15:8]} + 9'd1;
      square_ff <= (screen_ff[7:0] == screen_ff[15:8]);
      rsq_ff    <= 16'(radius) * 16'(radius);
   end

   // current code byte
   logic [7:0]       code_ff;
   logic             last_ff;
   logic [9:0]       sum_ff;
   logic             over_ff;
   logic [7:0]       gray_ff;
   logic             paint_ff;
   logic [RUN_W-1:0] run_left_ff;
   logic [PIX_W-1:0] pc_ff;
   logic             err_ff;

   logic [1:0]  level;
   logic [1:0]  level_inv;
   logic [6:0]  run_len;
   logic [9:0]  sum_in;
   logic [19:0] quot;
   logic [PIX_W-1:0] room;

   always_comb begin
      level     = code_ff[7:6];
      level_inv = 2'd3 - level;
      run_len   = {1'b0, code_ff[RUN_W-1:0]} + 7'd1;
      if (mode_ff == MODE_OPAQUE) begin
         sum_in = 10'(level_inv) * 10'(bg_ff) + 10'(level) * 10'(ink_ff);
      end else begin
         sum_in = 10'(level) * 10'(ink_ff);
      end
      quot = 20'(sum_ff) * 20'(DIV3_RECIP);
      room = total_ff - pc_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= code_byte;
         last_ff <= last_code;
      end
      if (cmd.calc) begin
         sum_ff  <= sum_in;
         over_ff <= err_ff || (pc_ff > total_ff) || (PIX_W'(run_len) > room);
      end
      if (cmd.check) begin
         if (mode_ff[1]) gray_ff <= (level != 2'd0) ? 8'd255 : 8'd0;
         else gray_ff <= quot[DIV3_SHIFT +: 8];
         paint_ff    <= (mode_ff == MODE_OPAQUE) || (level != 2'd0);
         run_left_ff <= code_ff[RUN_W-1:0];
      end else if (cmd.issue_pix) begin
         run_left_ff <= run_left_ff - RUN_W'(1);
      end
   end

   // sprite position counters
   logic [PIX_W-1:0] pc_in;
   logic [CNT_W-1:0] col_ff;
   logic [CNT_W-1:0] col_in;
   logic [CNT_W-1:0] row_ff;
   logic [CNT_W-1:0] row_in;
   logic             err_in;
   logic [PIX_W-1:0] pc_inc;
   logic [DIM_W-1:0] col_inc;
   logic             run_last;

   always_comb begin
      run_last = (run_left_ff == '0);
      pc_inc   = pc_ff + PIX_W'(1);
      col_inc  = DIM_W'(col_ff) + DIM_W'(1);
      pc_in    = pc_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      err_in   = err_ff;
      if (cmd.issue_pix) begin
         pc_in = pc_inc;
         if (col_inc >= w_ff) begin
            col_in = '0;
            row_in = row_ff + CNT_W'(1);
         end else begin
            col_in = col_inc[CNT_W-1:0];
         end
         if (run_last && last_ff) begin
            pc_in  = '0;
            col_in = '0;
            row_in = '0;
            err_in = 1'b0;
         end
      end else if (cmd.issue_err) begin
         if (last_ff) begin
            pc_in  = '0;
            col_in = '0;
            row_in = '0;
            err_in = 1'b0;
         end else begin
            err_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         pc_ff  <= pc_in;
         col_ff <= col_in;
         row_ff <= row_in;
         err_ff <= err_in;
      end
   end

   // pixel pipeline: position, border test, squares, circle test
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [16:0] s1_x_ff, s1_y_ff;
   logic [7:0]  s1_gray_ff;
   logic        s1_paint_ff, s1_end_ff;
   logic [1:0]  s1_status_ff;

   logic [16:0] s2_x_ff, s2_y_ff;
   logic [7:0]  s2_gray_ff;
   logic        s2_paint_ff, s2_end_ff, s2_inb_ff;
   logic [1:0]  s2_status_ff;
   logic [7:0]  s2_adx_ff, s2_ady_ff;

   logic [16:0] s3_x_ff, s3_y_ff;
   logic [7:0]  s3_gray_ff;
   logic        s3_paint_ff, s3_end_ff, s3_inb_ff;
   logic [1:0]  s3_status_ff;
   logic [15:0] s3_dx2_ff, s3_dy2_ff;

   logic [16:0] s4_x_ff, s4_y_ff;
   logic [7:0]  s4_gray_ff;
   logic        s4_we_ff, s4_end_ff;
   logic [1:0]  s4_status_ff;

   logic [16:0] sw_ext, sh_ext;
   logic        inb;
   logic [10:0] dx, dy, dx_abs, dy_abs;
   logic [16:0] dist_sq;
   logic        in_circle;

   assign adv = !v4_ff || rsp_ready;

   always_comb begin
      sw_ext = 17'(sw_ff);
      sh_ext = 17'(sh_ff);
      inb = !s1_x_ff[16] && (s1_x_ff != '0) && !s1_y_ff[16] && (s1_y_ff != '0)
            && (s1_x_ff < sw_ext - 17'd1) && (s1_y_ff < sh_ext - 17'd1);
      // centered offsets 2x+1-w, small once inside the border
      dx = {1'b0, s1_x_ff[8:0], 1'b1} - {2'b00, sw_ff};
      dy = {1'b0, s1_y_ff[8:0], 1'b1} - {2'b00, sh_ff};
      dx_abs = dx[10] ? (11'd0 - dx) : dx;
      dy_abs = dy[10] ? (11'd0 - dy) : dy;
      dist_sq = 17'(s3_dx2_ff) + 17'(s3_dy2_ff);
      in_circle = !square_ff || (dist_sq <= 17'(rsq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= cmd.issue_pix || cmd.issue_err;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (cmd.issue_err) begin
            s1_x_ff      <= '0;
            s1_y_ff      <= '0;
            s1_gray_ff   <= '0;
            s1_paint_ff  <= 1'b0;
            s1_end_ff    <= 1'b1;
            s1_status_ff <= STATUS_OVERFLOW;
         end else begin
            s1_x_ff      <= {origin_x_ff[15], origin_x_ff} + 17'(col_ff);
            s1_y_ff      <= {origin_y_ff[15], origin_y_ff} + 17'(row_ff);
            s1_gray_ff   <= gray_ff;
            s1_paint_ff  <= paint_ff;
            s1_end_ff    <= run_last;
            if (run_last && last_ff) begin
               s1_status_ff <= (pc_inc == total_ff) ? STATUS_COMPLETE : STATUS_SHORT;
            end else begin
               s1_status_ff <= STATUS_RUNNING;
            end
         end

         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_gray_ff   <= s1_gray_ff;
         s2_paint_ff  <= s1_paint_ff;
         s2_end_ff    <= s1_end_ff;
         s2_status_ff <= s1_status_ff;
         s2_inb_ff    <= inb;
         s2_adx_ff    <= dx_abs[7:0];
         s2_ady_ff    <= dy_abs[7:0];

         s3_x_ff      <= s2_x_ff;
         s3_y_ff      <= s2_y_ff;
         s3_gray_ff   <= s2_gray_ff;
         s3_paint_ff  <= s2_paint_ff;
         s3_end_ff    <= s2_end_ff;
         s3_status_ff <= s2_status_ff;
         s3_inb_ff    <= s2_inb_ff;
         s3_dx2_ff    <= 16'(s2_adx_ff) * 16'(s2_adx_ff);
         s3_dy2_ff    <= 16'(s2_ady_ff) * 16'(s2_ady_ff);

         s4_x_ff      <= s3_x_ff;
         s4_y_ff      <= s3_y_ff;
         s4_gray_ff   <= s3_gray_ff;
         s4_we_ff     <= s3_paint_ff && s3_inb_ff && in_circle;
         s4_end_ff    <= s3_end_ff;
         s4_status_ff <= s3_status_ff;
      end
   end

   assign stat.over       = over_ff;
   assign stat.run_last   = run_last;
   assign stat.pipe_ready = adv;

   assign rsp_valid     = v4_ff;
   assign pixel_x       = s4_x_ff;
   assign pixel_y       = s4_y_ff;
   assign gray_value    = s4_gray_ff;
   assign write_enable  = s4_we_ff;
   assign run_end       = s4_end_ff;
   assign sprite_status = s4_status_ff;

endmodule

// ===== sv/rle_gray_sprite_blitter.sv =====
// top level of the run-length gray sprite blitter
// a code byte passes the setup states CALC and CHECK, then gives one pixel per cycle while results do not stall
// an overflowing byte gives a single error result
// results leave through a 4-stage pixel pipeline
// a stalled result holds the pipeline and pauses pixel issue
// reset (synchronous) loads register defaults, clears the sprite counters and empties the pipeline
module rle_gray_sprite_blitter import rgsb_pkg::*; #(
   parameter int MAX_DIM = RGSB_MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   input  logic        req_tlast,   // last_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pixel_x[16:0], pixel_y[33:17], gray_value[41:34], zero
   output logic [2:0]  rsp_tuser,   // write_enable[0], sprite_status[2:1]
   output logic        rsp_tlast,   // run_end
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type     cmd;
   stat_type    stat;
   logic [16:0] pixel_x;
   logic [16:0] pixel_y;
   logic [7:0]  gray_value;
   logic        write_enable;
   logic [1:0]  sprite_status;

   rgsb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rgsb_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .code_byte     (req_tdata),
      .last_code     (req_tlast),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .pixel_x       (pixel_x),
      .pixel_y       (pixel_y),
      .gray_value    (gray_value),
      .write_enable  (write_enable),
      .run_end       (rsp_tlast),
      .sprite_status (sprite_status)
   );

   assign rsp_tdata = {6'd0, gray_value, pixel_y, pixel_x};
   assign rsp_tuser = {sprite_status, write_enable};

endmodule

// ===== sv/rgsb_checker.sv =====
// port-level checker for the sprite blitter, bound to the top level
`include "rle_gray_sprite_blitter_macros.svh"

module rgsb_checker import rgsb_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   `RGSB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a sprite status other than running only on the last result of a byte
   `RGSB_ASSERT_NOW(a_status_on_end, clock, reset, rsp_tvalid && (rsp_tuser[2:1] != STATUS_RUNNING), rsp_tlast)

   // overflow result is blank and never drawn
   `RGSB_ASSERT_NOW(a_overflow_blank, clock, reset, rsp_tvalid && (rsp_tuser[2:1] == STATUS_OVERFLOW), !rsp_tuser[0] && (rsp_tdata[41:0] == '0))

   // drawn pixels have positive coordinates, clear of the top and left border
   `RGSB_ASSERT_NOW(a_we_inside, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tdata[16] && (rsp_tdata[16:0] != '0) && !rsp_tdata[33] && (rsp_tdata[33:17] != '0))

   // one code byte in work at a time
   `RGSB_ASSERT_NEXT(a_one_byte, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind rle_gray_sprite_blitter rgsb_checker u_rgsb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== verif/rgsb_pixel_checker.sv =====
// pixel result checker for the sprite blitter: predicts each code byte's pixels and compares
`timescale 1ns / 1ps
module rgsb_pixel_checker import rgsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   input  logic        req_tlast,   // last_code
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // pixel_x[16:0], pixel_y[33:17], gray_value[41:34], zero
   input  logic [2:0]  rsp_tuser,   // write_enable[0], sprite_status[2:1]
   input  logic        rsp_tlast,   // run_end
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          pending,
   output int          fail_count
);

   typedef struct packed {
      logic signed [16:0] px;
      logic signed [16:0] py;
      logic [7:0]         gray;
      logic               we;
      logic               run_end;
      logic [1:0]         status;
   } pixel_type;

   pixel_type expected_pixels[$];
   pixel_type head;

   // register copies
   logic [8:0]         spr_w;
   logic [8:0]         spr_h;
   logic signed [15:0] org_x;
   logic signed [15:0] org_y;
   logic [7:0]         ink;
   logic [7:0]         bg;
   logic [1:0]         mode;
   logic [15:0]        screen;

   // sprite walk state
   logic [16:0] pix_cnt;
   logic [7:0]  col;
   logic [8:0]  row;
   logic        err_flag;

   function automatic int clamp_side(input logic [8:0] raw);
      if (raw < 9'd1) return 1;
      if (int'(raw) > RGSB_MAX_DIM) return RGSB_MAX_DIM;
      return int'(raw);
   endfunction

   function automatic void start_new_sprite();
      pix_cnt  = '0;
      col      = '0;
      row      = '0;
      err_flag = 1'b0;
   endfunction

   // one-pixel border, plus the inscribed circle on a square screen
   function automatic logic on_screen(input int x, input int y);
      int     sw;
      int     sh;
      longint dx;
      longint dy;
      longint r;
      sw = int'(screen[7:0]) + 1;
      sh = int'(screen[15:8]) + 1;
      if (x < 1 || y < 1 || x >= sw - 1 || y >= sh - 1) return 1'b0;
      if (sw == sh) begin
         dx = 2 * longint'(x) + 1 - sw;
         dy = 2 * longint'(y) + 1 - sh;
         r  = longint'(sw) - 2;
         if (dx * dx + dy * dy > r * r) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void expand_code(input logic [7:0] code, input logic fin);
      int        lvl;
      int        run_len;
      int        w;
      int        total;
      int        x;
      int        y;
      int        shade;
      pixel_type p;
      lvl     = int'(code[7:6]);
      run_len = int'(code[5:0]) + 1;
      w       = clamp_side(spr_w);
      total   = w * clamp_side(spr_h);
      if (err_flag || int'(pix_cnt) > total || run_len > total - int'(pix_cnt)) begin
         p         = '0;
         p.run_end = 1'b1;
         p.status  = STATUS_OVERFLOW;
         expected_pixels.push_back(p);
         if (fin) start_new_sprite();
         else err_flag = 1'b1;
         return;
      end
      for (int k = 0; k < run_len; k++) begin
         x = int'(org_x) + int'(col);
         y = int'(org_y) + int'(row);
         if (mode == MODE_OPAQUE) begin
            shade = ((3 - lvl) * int'(bg) + lvl * int'(ink)) / 3;
            p.we  = on_screen(x, y);
         end else if (lvl == 0) begin
            shade = 0;
            p.we  = 1'b0;
         end else begin
            // anything but scaled ink draws mono white
            shade = (mode == MODE_SCALED) ? (lvl * int'(ink)) / 3 : 255;
            p.we  = on_screen(x, y);
         end
         pix_cnt = pix_cnt + 17'd1;
         if (int'(col) + 1 >= w) begin
            col = '0;
            row = row + 9'd1;
         end else begin
            col = col + 8'd1;
         end
         p.px      = x[16:0];
         p.py      = y[16:0];
         p.gray    = shade[7:0];
         p.run_end = (k == run_len - 1);
         p.status  = STATUS_RUNNING;
         if (p.run_end && fin)
            p.status = (int'(pix_cnt) == total) ? STATUS_COMPLETE : STATUS_SHORT;
         expected_pixels.push_back(p);
      end
      if (fin) start_new_sprite();
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         spr_w      = 9'd1;
         spr_h      = 9'd1;
         org_x      = '0;
         org_y      = '0;
         ink        = 8'd0;
         bg         = 8'd255;
         mode       = MODE_OPAQUE;
         screen     = 16'd46248;
         start_new_sprite();
         expected_pixels.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SPRITE_WIDTH:  spr_w  = csr_wdata[8:0];
               CSR_SPRITE_HEIGHT: spr_h  = csr_wdata[8:0];
               CSR_ORIGIN_X:      org_x  = csr_wdata;
               CSR_ORIGIN_Y:      org_y  = csr_wdata;
               CSR_INK_LEVEL:     ink    = csr_wdata[7:0];
               CSR_BG_LEVEL:      bg     = csr_wdata[7:0];
               CSR_DRAW_MODE:     mode   = csr_wdata[1:0];
               CSR_SCREEN_SIZE:   screen = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expand_code(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("result transfer with nothing expected: pixel_x %0d, pixel_y %0d",
                      $signed(rsp_tdata[16:0]), $signed(rsp_tdata[33:17]));
               fail_count++;
            end else begin
               head = expected_pixels.pop_front();
               check_field("pixel_x", int'(head.px), int'($signed(rsp_tdata[16:0])));
               check_field("pixel_y", int'(head.py), int'($signed(rsp_tdata[33:17])));
               check_field("gray_value", int'(head.gray), int'(rsp_tdata[41:34]));
               check_field("write_enable", int'(head.we), int'(rsp_tuser[0]));
               check_field("run_end", int'(head.run_end), int'(rsp_tlast));
               check_field("sprite_status", int'(head.status), int'(rsp_tuser[2:1]));
            end
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the sprite blitter: code byte stimulus, register setup and verdict
`timescale 1ns / 1ps
module tb_top;
   import rgsb_pkg::*;

   localparam int ITEM_GOAL   = 380;
   localparam int QUIET_LIMIT = 2000;

   // mode two is mono white, mode three acts the same
   localparam logic [1:0] MODE_MONO     = 2'd2;
   localparam logic [1:0] MODE_MONO_ALT = 2'd3;

   localparam int SPRITE_EXACT   = 0;
   localparam int SPRITE_SHORT   = 1;
   localparam int SPRITE_OVERRUN = 2;
   localparam int SPRITE_NOISE   = 3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int pending;
   int checker_fails;
   int items_sent;
   int quiet_cycles = 0;
   bit idle_on;

   // register values as last written
   int          cfg_w;
   int          cfg_h;
   logic [15:0] cfg_ox;
   logic [15:0] cfg_oy;
   logic [7:0]  cfg_ink;
   logic [7:0]  cfg_bg;
   logic [1:0]  cfg_mode;
   logic [15:0] cfg_screen;

   rle_gray_sprite_blitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rgsb_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (checker_fails)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int min2(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int dim(input int raw);
      if (raw < 1) return 1;
      if (raw > RGSB_MAX_DIM) return RGSB_MAX_DIM;
      return raw;
   endfunction

   function automatic logic [7:0] make_code(input int run);
      return {2'($urandom), 6'(run - 1)};
   endfunction

   task automatic send_code(input logic [7:0] code, input logic fin);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // runs adding up to count pixels, last_code on the final byte when closing
   task automatic emit_pixels(input int count, input bit close);
      int cap;
      int run;
      cap = ($urandom_range(0, 2) == 0) ? 64 : 8;
      while (count > 0) begin
         run   = $urandom_range(1, min2(cap, count));
         count = count - run;
         send_code(make_code(run), close && count == 0);
      end
   endtask

   task automatic send_sprite(input int shape);
      int total;
      int spare;
      total = dim(cfg_w) * dim(cfg_h);
      case (shape)
         SPRITE_EXACT: emit_pixels(total, 1'b1);
         SPRITE_SHORT: emit_pixels((total > 1) ? $urandom_range(1, total - 1) : total, 1'b1);
         SPRITE_OVERRUN: begin
            spare = $urandom_range(0, min2(63, total));
            emit_pixels(total - spare, 1'b0);
            send_code(make_code($urandom_range(spare + 1, 64)), 1'b0);
            // bytes after the error, then one to close the sprite
            repeat ($urandom_range(0, 2)) send_code(8'($urandom), 1'b0);
            send_code(8'($urandom), 1'b1);
         end
         default: begin
            repeat ($urandom_range(1, 5)) send_code(8'($urandom), $urandom_range(0, 2) == 0);
         end
      endcase
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_setup();
      write_reg(CSR_SPRITE_WIDTH, 16'(cfg_w));
      write_reg(CSR_SPRITE_HEIGHT, 16'(cfg_h));
      write_reg(CSR_ORIGIN_X, cfg_ox);
      write_reg(CSR_ORIGIN_Y, cfg_oy);
      write_reg(CSR_INK_LEVEL, {8'd0, cfg_ink});
      write_reg(CSR_BG_LEVEL, {8'd0, cfg_bg});
      write_reg(CSR_DRAW_MODE, {14'd0, cfg_mode});
      write_reg(CSR_SCREEN_SIZE, cfg_screen);
      csr_we <= 1'b0;
   endtask

   task automatic pick_setup();
      logic [7:0] side;
      case ($urandom_range(0, 9))
         0: begin
            cfg_w = 256;
            cfg_h = $urandom_range(1, 2);
         end
         1: begin
            cfg_w = $urandom_range(1, 2);
            cfg_h = 256;
         end
         2: begin
            // out-of-range sizes clamp
            cfg_w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
            cfg_h = $urandom_range(0, 3);
         end
         default: begin
            cfg_w = $urandom_range(1, 9);
            cfg_h = $urandom_range(1, 9);
         end
      endcase
      cfg_ox = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 28)) - 4);
      cfg_oy = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 28)) - 4);
      cfg_ink  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
      cfg_bg   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
      cfg_mode = 2'($urandom);
      case ($urandom_range(0, 5))
         0: cfg_screen = 16'h0303;
         1: cfg_screen = 16'hFFFF;
         2: cfg_screen = 16'($urandom_range(771, 65535));
         default: begin
            side       = 8'($urandom_range(3, 30));
            cfg_screen = {side, side};
         end
      endcase
   endtask

   // drain every expected result, then give the pipeline time to empty
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int phase_end;
      int shape_pick;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      idle_on    = 1'b1;
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset setup: one-pixel sprite completes, then a run too long for it
      send_code(8'h80, 1'b1);
      send_code(8'h01, 1'b1);
      settle();

      // widest sprite at the far corner, all four levels, longest runs
      cfg_w      = 256;
      cfg_h      = 1;
      cfg_ox     = 16'h7FFF;
      cfg_oy     = 16'h8000;
      cfg_ink    = 8'hFF;
      cfg_bg     = 8'h00;
      cfg_mode   = MODE_OPAQUE;
      cfg_screen = 16'hFFFF;
      load_setup();
      send_code(8'h3F, 1'b0);
      send_code(8'h7F, 1'b0);
      send_code(8'hBF, 1'b0);
      send_code(8'hFF, 1'b1);
      settle();

      // clamped sizes, scaled ink, smallest screen, sprite ends short
      cfg_w      = 0;
      cfg_h      = 511;
      cfg_ox     = 16'h8000;
      cfg_oy     = 16'h7FFF;
      cfg_ink    = 8'd200;
      cfg_bg     = 8'hFF;
      cfg_mode   = MODE_SCALED;
      cfg_screen = 16'h0303;
      load_setup();
      send_code(8'h3F, 1'b0);
      send_code(8'h7F, 1'b0);
      send_code(8'hBF, 1'b1);
      settle();

      // mono white inside a circle, then overrun and bytes after the error
      cfg_w      = 4;
      cfg_h      = 4;
      cfg_ox     = 16'h0000;
      cfg_oy     = 16'h0000;
      cfg_ink    = 8'd17;
      cfg_bg     = 8'd99;
      cfg_mode   = MODE_MONO;
      cfg_screen = 16'h0505;
      load_setup();
      send_code(8'h4F, 1'b1);
      send_code(8'h8F, 1'b0);
      send_code(8'hC0, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'h45, 1'b1);
      settle();

      // mode three on a non-square screen, first byte overruns, level zero transparent
      cfg_ox     = 16'h0001;
      cfg_oy     = 16'h0001;
      cfg_mode   = MODE_MONO_ALT;
      cfg_screen = 16'h0807;
      load_setup();
      send_code(8'hD3, 1'b0);
      send_code(8'h00, 1'b1);
      send_code(8'h0F, 1'b1);

      items_sent = 0;
      while (items_sent < ITEM_GOAL) begin
         settle();
         pick_setup();
         load_setup();
         // no idling in the closing stretch
         idle_on   = (items_sent < ITEM_GOAL - 80) && ($urandom_range(0, 3) != 0);
         phase_end = items_sent + $urandom_range(15, 40);
         while (items_sent < phase_end) begin
            shape_pick = $urandom_range(0, 9);
            send_sprite(shape_pick < 5 ? SPRITE_EXACT :
                        shape_pick < 7 ? SPRITE_SHORT :
                        shape_pick < 9 ? SPRITE_OVERRUN : SPRITE_NOISE);
         end
      end
      settle();

      if (checker_fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
